// ----- rtl/core/rgbt_pkg.sv -----
package rgbt_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_WIDTH_TILES   = 2'd0;
   localparam logic [1:0] CSR_HEIGHT_TILES  = 2'd1;
   localparam logic [1:0] CSR_CHANNEL_ORDER = 2'd2;

   localparam int CSR_DATA_W  = 9;
   localparam int CSR_INDEX_W = 2;

   // register reset values
   localparam logic [8:0] WIDTH_TILES_RESET  = 9'd64;
   localparam logic [8:0] HEIGHT_TILES_RESET = 9'd48;

   // channel order codes
   localparam logic ORDER_RED_LOW  = 1'b0;
   localparam logic ORDER_BLUE_LOW = 1'b1;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // pixel data that rides along with the position
   typedef struct packed {
      logic [15:0] ar_pair;
      logic [15:0] gb_pair;
      logic        frame_last;
   } pix_type;

endpackage

// ----- rtl/core/rgba8_four_by_four_texture_tiler.sv -----
// channel | ports                                   | beat taken when
// --------+-----------------------------------------+------------------
// input   | push, full, req_pixel                   | push && !full
// result  | pop, empty, rsp_ar_/gb_address/pair,    | pop && !empty
//         | rsp_frame_last                          |
// config  | csr_write, csr_index, csr_data          | csr_write
//
// One pixel per clock sustained while the result side pops. A pushed beat is
// written into the four-entry queue and waits at its head; from there the
// back end multiply (tile row times tiles per row) loads the output register.
// Synchronous reset clears the counters, the queue and the output register
// and loads the size registers with 64 by 48 tiles, red in the low byte.
// A stalled result side fills the queue; full rises once five beats wait,
// four in the queue and one in the output register.
module rgba8_four_by_four_texture_tiler #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic [31:0]                      req_pixel,
   output logic                             empty,
   input  logic                             pop,
   output logic [21:0]                      rsp_ar_address,
   output logic [15:0]                      rsp_ar_pair,
   output logic [21:0]                      rsp_gb_address,
   output logic [15:0]                      rsp_gb_pair,
   output logic                             rsp_frame_last,
   input  logic                             csr_write,
   input  logic [rgbt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rgbt_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rgbt_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int PXW = $bits(pix_type);
   localparam int QW = CW + RW + 9 + PXW;

   logic          accept;
   logic          q_full;
   logic          q_empty;
   logic          q_pop;
   logic [CW-1:0] f_col;
   logic [RW-1:0] f_row;
   logic [8:0]    f_tw;
   pix_type       f_pix;
   logic [QW-1:0] q_wdata;
   logic [QW-1:0] q_rdata;
   logic [CW-1:0] h_col;
   logic [RW-1:0] h_row;
   logic [8:0]    h_tw;
   pix_type       h_pix;

   assign full   = q_full;
   assign accept = push && !q_full;

   // front: position counters, config and channel pairing
   rgbt_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .take      (accept),
      .pixel     (req_pixel),
      .col_out   (f_col),
      .row_out   (f_row),
      .tw_out    (f_tw),
      .pix_out   (f_pix)
   );

   // queue between front and back
   assign q_wdata = {f_col, f_row, f_tw, f_pix};

   rgbt_queue #(
      .W (QW)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (accept),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   assign {h_col, h_row, h_tw, h_pix} = q_rdata;

   // back: address arithmetic and result register
   rgbt_back #(
      .CW (CW),
      .RW (RW)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (!q_empty),
      .head_col       (h_col),
      .head_row       (h_row),
      .head_tw        (h_tw),
      .head_pix       (h_pix),
      .head_take      (q_pop),
      .pop            (pop),
      .empty          (empty),
      .rsp_ar_address (rsp_ar_address),
      .rsp_ar_pair    (rsp_ar_pair),
      .rsp_gb_address (rsp_gb_address),
      .rsp_gb_pair    (rsp_gb_pair),
      .rsp_frame_last (rsp_frame_last)
   );

`ifndef SYNTH
   // counters restart after the last pixel of a frame
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && f_pix.frame_last) |=> (f_col == '0 && f_row == '0))
      else $error("position counters did not wrap after frame end");

   // green/blue pair always sits 32 bytes above the alpha/red pair
   a_gb_offset: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_gb_address == rsp_ar_address + 22'd32))
      else $error("gb address not ar address plus 32");

   // a full queue cannot be empty
   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_empty)
      else $error("queue full and empty at once");
`endif

endmodule

// ----- rtl/core/rgbt_queue.sv -----
module rgbt_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] wdata,
   input  logic         pop,
   output logic [W-1:0] rdata,
   output logic         full,
   output logic         empty
);
   import rgbt_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [NW-1:0] DEPTH_N = NW'(QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

   logic [W-1:0]  store_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full    = (count_ff == DEPTH_N);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- rtl/core/rgbt_front.sv -----
module rgbt_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int RW = $clog2(MAX_HEIGHT)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [rgbt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rgbt_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                take,
   input  logic [31:0]                         pixel,
   output logic [CW-1:0]                       col_out,
   output logic [RW-1:0]                       row_out,
   output logic [8:0]                          tw_out,
   output rgbt_pkg::pix_type                   pix_out
);
   import rgbt_pkg::*;

   // saturation limits for the tile counts
   localparam int W_HI  = (MAX_WIDTH / 4 < 1) ? 1 : MAX_WIDTH / 4;
   localparam int H_HI  = (MAX_HEIGHT / 4 < 1) ? 1 : MAX_HEIGHT / 4;
   localparam int W_CAPI = (W_HI > 511) ? 511 : W_HI;
   localparam int H_CAPI = (H_HI > 511) ? 511 : H_HI;
   localparam logic [8:0] W_CAP = 9'(W_CAPI);
   localparam logic [8:0] H_CAP = 9'(H_CAPI);
   localparam int CWC = (CW + 1 > 11) ? CW + 1 : 11;
   localparam int RWC = (RW + 1 > 11) ? RW + 1 : 11;

   logic [8:0]    width_ff;
   logic [8:0]    height_ff;
   logic          order_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [8:0]    tw;
   logic [8:0]    th;
   logic          line_end;
   logic          last;
   logic [7:0]    red;
   logic [7:0]    blue;

   // clamp the tile counts into range
   always_comb begin
      if (width_ff == '0) begin
         tw = 9'd1;
      end else if (width_ff > W_CAP) begin
         tw = W_CAP;
      end else begin
         tw = width_ff;
      end
      if (height_ff == '0) begin
         th = 9'd1;
      end else if (height_ff > H_CAP) begin
         th = H_CAP;
      end else begin
         th = height_ff;
      end
   end

   // end of line and end of frame
   assign line_end = (CWC'(col_ff) + CWC'(1)) >= CWC'({tw, 2'b00});
   assign last     = line_end && ((RWC'(row_ff) + RWC'(1)) >= RWC'({th, 2'b00}));

   // next raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (take) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (line_end) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // config registers and position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_TILES_RESET;
         height_ff <= HEIGHT_TILES_RESET;
         order_ff  <= ORDER_RED_LOW;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_WIDTH_TILES:   width_ff  <= csr_data;
               CSR_HEIGHT_TILES:  height_ff <= csr_data;
               CSR_CHANNEL_ORDER: order_ff  <= csr_data[0];
               default: ;
            endcase
         end
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // channel swap and pairing
   assign red  = (order_ff == ORDER_BLUE_LOW) ? pixel[23:16] : pixel[7:0];
   assign blue = (order_ff == ORDER_BLUE_LOW) ? pixel[7:0] : pixel[23:16];

   assign col_out            = col_ff;
   assign row_out            = row_ff;
   assign tw_out             = tw;
   assign pix_out.ar_pair    = {pixel[31:24], red};
   assign pix_out.gb_pair    = {pixel[15:8], blue};
   assign pix_out.frame_last = last;

endmodule

// ----- rtl/core/rgbt_back.sv -----
module rgbt_back #(
   parameter int CW = 10,
   parameter int RW = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  logic [CW-1:0]     head_col,
   input  logic [RW-1:0]     head_row,
   input  logic [8:0]        head_tw,
   input  rgbt_pkg::pix_type head_pix,
   output logic              head_take,
   input  logic              pop,
   output logic              empty,
   output logic [21:0]       rsp_ar_address,
   output logic [15:0]       rsp_ar_pair,
   output logic [21:0]       rsp_gb_address,
   output logic [15:0]       rsp_gb_pair,
   output logic              rsp_frame_last
);
   import rgbt_pkg::*;

   logic              out_valid_ff, out_valid_in;
   logic [21:0]       ar_ff, ar_in;
   pix_type           pix_ff;
   logic [RW+8:0]     prod;
   logic [21:0]       tile;
   logic [3:0]        idx;

   // tile number: tile row times tiles per row plus tile column
   assign prod = (RW+9)'(head_row >> 2) * (RW+9)'(head_tw);
   assign tile = 22'(prod) + 22'(head_col >> 2);
   assign idx  = {head_row[1:0], head_col[1:0]};
   assign ar_in = {tile[15:0], 1'b0, idx, 1'b0};

   // refill the output register when it is free or being drained
   assign head_take    = head_valid && (!out_valid_ff || pop);
   assign out_valid_in = head_take || (out_valid_ff && !pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_take) begin
         ar_ff  <= ar_in;
         pix_ff <= head_pix;
      end
   end

   // green/blue half sits 32 bytes above, bit 5 of ar is always clear
   assign empty          = !out_valid_ff;
   assign rsp_ar_address = ar_ff;
   assign rsp_gb_address = {ar_ff[21:6], 1'b1, ar_ff[4:0]};
   assign rsp_ar_pair    = pix_ff.ar_pair;
   assign rsp_gb_pair    = pix_ff.gb_pair;
   assign rsp_frame_last = pix_ff.frame_last;

endmodule
